>>> hdl/ldf_pkg.sv
// Package for the lidar frame deframer: frame constants, status codes and
// the item type passed from the input register to the frame parser.
// No dependencies.
package ldf_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'hAA;
    localparam logic [7:0] FTR_BYTE   = 8'h55;
    localparam logic [3:0] FRAME_LAST = 4'd13;
    localparam logic [3:0] XOR_LAST   = 4'd11;
    localparam logic [3:0] CHK_POS    = 4'd12;
    localparam logic [3:0] POS_HUNT   = 4'd0;

    typedef enum logic [1:0]
    {
        STATUS_OK           = 2'd0,
        STATUS_BAD_FOOTER   = 2'd1,
        STATUS_BAD_CHECKSUM = 2'd2
    } frame_status_t;

    typedef struct packed
    {
        logic       valid;
        logic [7:0] data;
    } byte_item_t;

endpackage

>>> hdl/ldf_input_stage.sv
// Input register of the lidar frame deframer: captures one received byte
// per item and holds it until the frame parser takes it. Uses ldf_pkg.
module ldf_input_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output ldf_pkg::byte_item_t item,
    input  logic              take
);
    import ldf_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;

    // Stall while a held item cannot move on
    assign in_stall = valid_reg && !take;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture the item payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = byte_reg;

endmodule

>>> hdl/ldf_frame_parser.sv
// Frame parser of the lidar frame deframer: tracks the byte position,
// gathers fields and the XOR, and registers one result per frame.
// Uses ldf_pkg; fed by ldf_input_stage.
module ldf_frame_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  ldf_pkg::byte_item_t item,
    output logic                take,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          frame_status,
    output logic [15:0]         distance_mm,
    output logic signed [15:0]  angle_tenths,
    output logic [31:0]         timestamp_ms
);
    import ldf_pkg::*;

    logic [3:0]    pos_reg,   pos_next;
    logic [7:0]    xor_reg,   xor_next;
    logic [7:0]    chk_reg,   chk_next;
    logic [15:0]   dist_reg,  dist_next;
    logic [15:0]   ang_reg,   ang_next;
    logic [31:0]   ts_reg,    ts_next;

    logic          out_valid_reg;
    frame_status_t status_reg;
    logic [15:0]   dist_out_reg;
    logic [15:0]   ang_out_reg;
    logic [31:0]   ts_out_reg;

    logic          proc;
    logic          hunting;
    logic          frame_end;
    frame_status_t status_next;

    // Advance when the result register is free or being drained
    assign take      = !out_valid_reg || !out_stall;
    assign proc      = item.valid && take;
    assign hunting   = (pos_reg inside {POS_HUNT, [4'd14:4'd15]});
    assign frame_end = !hunting && (pos_reg == FRAME_LAST);

    // Next position, XOR and field holds
    always_comb
    begin
        pos_next  = pos_reg;
        xor_next  = xor_reg;
        chk_next  = chk_reg;
        dist_next = dist_reg;
        ang_next  = ang_reg;
        ts_next   = ts_reg;
        if (proc)
        begin
            if (hunting)
            begin
                pos_next = POS_HUNT;
                if (item.data == HDR_BYTE)
                begin
                    pos_next = 4'd1;
                    xor_next = 8'd0;
                end
            end
            else
            begin
                if (pos_reg <= XOR_LAST)
                begin
                    xor_next = xor_reg ^ item.data;
                end
                case (pos_reg)
                    4'd2:    dist_next[7:0]   = item.data;
                    4'd3:    dist_next[15:8]  = item.data;
                    4'd4:    ang_next[7:0]    = item.data;
                    4'd5:    ang_next[15:8]   = item.data;
                    4'd6:    ts_next[7:0]     = item.data;
                    4'd7:    ts_next[15:8]    = item.data;
                    4'd8:    ts_next[23:16]   = item.data;
                    4'd9:    ts_next[31:24]   = item.data;
                    CHK_POS: chk_next         = item.data;
                    default: ;
                endcase
                pos_next = frame_end ? POS_HUNT : pos_reg + 4'd1;
            end
        end
    end

    // Check footer first, then checksum
    always_comb
    begin
        if (item.data != FTR_BYTE)
        begin
            status_next = STATUS_BAD_FOOTER;
        end
        else if (xor_reg != chk_reg)
        begin
            status_next = STATUS_BAD_CHECKSUM;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_HUNT;
            xor_reg  <= 8'd0;
            chk_reg  <= 8'd0;
            dist_reg <= 16'd0;
            ang_reg  <= 16'd0;
            ts_reg   <= 32'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            xor_reg  <= xor_next;
            chk_reg  <= chk_next;
            dist_reg <= dist_next;
            ang_reg  <= ang_next;
            ts_reg   <= ts_next;
        end
    end

    // Result valid: set on the footer byte, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= proc && frame_end;
        end
    end

    // Result payload; zero the fields of a bad frame
    always_ff @(posedge clk)
    begin
        if (proc && frame_end)
        begin
            status_reg <= status_next;
            if (status_next == STATUS_OK)
            begin
                dist_out_reg <= dist_reg;
                ang_out_reg  <= ang_reg;
                ts_out_reg   <= ts_reg;
            end
            else
            begin
                dist_out_reg <= 16'd0;
                ang_out_reg  <= 16'd0;
                ts_out_reg   <= 32'd0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = status_reg;
    assign distance_mm  = dist_out_reg;
    assign angle_tenths = signed'(ang_out_reg);
    assign timestamp_ms = ts_out_reg;

endmodule

>>> hdl/lidar_frame_deframer.sv
// Lidar frame deframer top level: input register feeding the frame parser.
// The result item is registered when the footer byte is accepted, is valid in
// the cycle after, and is held until taken while out_stall is high.
// Throughput: one byte per cycle, set by the single-pass parser stage, unless
// out_stall holds a result. Reset: rst_n asynchronous active low; returns to
// hunting for the header and clears the input and result valid flags.
module lidar_frame_deframer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         frame_status,
    output logic [15:0]        distance_mm,
    output logic signed [15:0] angle_tenths,
    output logic [31:0]        timestamp_ms
);
    import ldf_pkg::*;

    byte_item_t item;
    logic       take;

    ldf_input_stage u_input
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .item     (item),
        .take     (take)
    );

    ldf_frame_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .take         (take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_status (frame_status),
        .distance_mm  (distance_mm),
        .angle_tenths (angle_tenths),
        .timestamp_ms (timestamp_ms)
    );

endmodule
